// ===== rtl/core/efr_pkg.sv =====
// Shared types, constants and register codes for the escaped frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam int MAX_W       = 9;
  localparam int CAP_W       = (POS_W > MAX_W) ? POS_W : MAX_W;
  localparam int ERR_W       = 32;
  localparam int IDX_W       = 2;

  localparam logic [7:0]       HEAD_RESET = 8'hAA;
  localparam logic [7:0]       TAIL_RESET = 8'h55;
  localparam logic [7:0]       ESC_RESET  = 8'hA5;
  localparam logic [MAX_W-1:0] MAX_RESET  = 9'd256;

  localparam logic [IDX_W-1:0] REG_HEAD = 2'd0;
  localparam logic [IDX_W-1:0] REG_TAIL = 2'd1;
  localparam logic [IDX_W-1:0] REG_ESC  = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX  = 2'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_GOOD = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  typedef struct packed {
    logic [7:0]       head;
    logic [7:0]       tail;
    logic [7:0]       esc;
    logic [MAX_W-1:0] max_size;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       length;
    logic [ERR_W-1:0] errors;
  } res_t;

endpackage

// ===== rtl/core/efr_cfg_regs.sv =====
// Configuration registers of the escaped frame receiver.
`timescale 1ns / 1ps

module efr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [efr_pkg::IDX_W-1:0]    wr_index_i,
  input  logic [efr_pkg::MAX_W-1:0]    wr_data_i,
  output efr_pkg::cfg_t                cfg_o
);

  efr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        efr_pkg::REG_HEAD: cfg_d.head     = wr_data_i[7:0];
        efr_pkg::REG_TAIL: cfg_d.tail     = wr_data_i[7:0];
        efr_pkg::REG_ESC:  cfg_d.esc      = wr_data_i[7:0];
        efr_pkg::REG_MAX:  cfg_d.max_size = wr_data_i;
        default:           cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head     <= efr_pkg::HEAD_RESET;
      cfg_q.tail     <= efr_pkg::TAIL_RESET;
      cfg_q.esc      <= efr_pkg::ESC_RESET;
      cfg_q.max_size <= efr_pkg::MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/efr_store.sv =====
// Frame byte store with one write port and a registered read port.
`timescale 1ns / 1ps

module efr_store (
  input  logic                         clk_i,
  input  efr_pkg::wr_t                 wr_i,
  input  logic                         rd_en_i,
  input  logic                         rd_ok_i,
  input  logic [efr_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [7:0]                   rd_data_o
);

  logic [7:0] mem_q [efr_pkg::STORE_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rd_ok_i ? mem_q[rd_addr_i] : 8'd0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/efr_frame_ctrl.sv =====
// Frame tracking: marker detection, unescaping, checksum and error counting.
`timescale 1ns / 1ps

module efr_frame_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          opcode_i,
  input  logic [7:0]    rx_byte_i,
  input  efr_pkg::cfg_t cfg_i,
  output efr_pkg::wr_t  wr_o,
  output efr_pkg::res_t res_o
);

  logic [7:0]                prev_q, prev_d;
  logic                      recv_q, recv_d;
  logic                      esc_q, esc_d;
  logic [efr_pkg::POS_W-1:0] wpos_q, wpos_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                len_q, len_d;
  logic [efr_pkg::ERR_W-1:0] err_q, err_d;
  logic [7:0]                last_q, ck_q;

  logic                      push;
  logic                      head_dbl, close, data, set_esc, full, restart, store;
  logic [efr_pkg::CAP_W-1:0] cap;
  logic [7:0]                ck_sum;
  logic                      short_frame, bad;
  logic [efr_pkg::POS_W-1:0] len_pos;

  always_comb begin
    push     = step_i && (opcode_i == efr_pkg::OP_PUSH);
    head_dbl = (rx_byte_i == cfg_i.head) && (prev_q == cfg_i.head);
    close    = !head_dbl && (rx_byte_i == cfg_i.tail) && (prev_q == cfg_i.tail) && recv_q;
    data     = !head_dbl && !close && recv_q && (esc_q || (rx_byte_i != cfg_i.esc));
    set_esc  = !head_dbl && !close && recv_q && !esc_q && (rx_byte_i == cfg_i.esc);
    cap      = (efr_pkg::CAP_W'(cfg_i.max_size) < efr_pkg::CAP_W'(efr_pkg::STORE_DEPTH)) ?
               efr_pkg::CAP_W'(cfg_i.max_size) : efr_pkg::CAP_W'(efr_pkg::STORE_DEPTH);
    full     = efr_pkg::CAP_W'(wpos_q) >= cap;
    restart  = head_dbl || (data && full);
    store    = data && !full;

    short_frame = wpos_q < efr_pkg::POS_W'(2);
    ck_sum      = sum_q - cfg_i.tail - ck_q;
    bad         = short_frame || (ck_sum != ck_q);
    len_pos     = wpos_q - efr_pkg::POS_W'(2);
  end

  always_comb begin
    prev_d = prev_q;
    recv_d = recv_q;
    esc_d  = esc_q;
    wpos_d = wpos_q;
    sum_d  = sum_q;
    len_d  = len_q;
    err_d  = err_q;
    res_o.status = efr_pkg::STAT_NONE;
    if (push) begin
      if (restart) begin
        prev_d = rx_byte_i;
        recv_d = 1'b1;
        esc_d  = 1'b0;
        wpos_d = '0;
        sum_d  = '0;
        if (recv_q) begin
          err_d = err_q + efr_pkg::ERR_W'(1);
        end
      end else if (close) begin
        prev_d = rx_byte_i;
        recv_d = 1'b0;
        esc_d  = 1'b0;
        sum_d  = '0;
        wpos_d = (wpos_q == '0) ? '0 : wpos_q - efr_pkg::POS_W'(1);
        len_d  = short_frame ? 8'd0 : len_pos[7:0];
        res_o.status = bad ? efr_pkg::STAT_BAD : efr_pkg::STAT_GOOD;
        if (bad) begin
          err_d = err_q + efr_pkg::ERR_W'(1);
        end
      end else begin
        prev_d = (store && esc_q) ? cfg_i.esc : rx_byte_i;
        if (set_esc) begin
          esc_d = 1'b1;
        end else if (data) begin
          esc_d = 1'b0;
        end
        if (store) begin
          wpos_d = wpos_q + efr_pkg::POS_W'(1);
          sum_d  = sum_q + rx_byte_i;
        end
      end
    end
    res_o.length = len_d;
    res_o.errors = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      recv_q <= 1'b0;
      esc_q  <= 1'b0;
      wpos_q <= '0;
      sum_q  <= '0;
      len_q  <= '0;
      err_q  <= '0;
    end else begin
      prev_q <= prev_d;
      recv_q <= recv_d;
      esc_q  <= esc_d;
      wpos_q <= wpos_d;
      sum_q  <= sum_d;
      len_q  <= len_d;
      err_q  <= err_d;
    end
  end

  // hold the two most recent stored bytes; the older one is the checksum at close
  always_ff @(posedge clk_i) begin
    if (push && store) begin
      last_q <= rx_byte_i;
      ck_q   <= last_q;
    end
  end

  assign wr_o.en      = push && store;
  assign wr_o.addr    = wpos_q[efr_pkg::ADDR_W-1:0];
  assign wr_o.data    = rx_byte_i;

endmodule

// ===== rtl/core/escaped_frame_receiver.sv =====
// Top level of the escaped frame receiver: input register, frame logic, result register.
//
//  channel   | dir | handshake                      | content
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | tuser opcode, tdata rx_byte, read_index
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata status, length, read data, errors
//  cfg       | in  | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while m_axis is not stalled; each item passes through the input
// register and then the result register and the registered store read to m_axis.
// Reset clears control state and returns configuration to its defaults; the byte store is not cleared.
// A stalled m_axis holds the result register and then the input register,
// after which s_axis_tready drops.
`timescale 1ns / 1ps

module escaped_frame_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // rx_byte, read_index
  input  logic                      s_axis_tuser,  // opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata,  // frame_status, payload_length,
                                                   // read_data, error_total, zero pad
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [efr_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [efr_pkg::MAX_W-1:0] cfg_data_i
);

  logic          in_vld_q;
  logic          in_op_q;
  logic [7:0]    in_byte_q;
  logic [7:0]    in_idx_q;
  logic          out_vld_q;
  efr_pkg::res_t res_q;
  efr_pkg::res_t res;
  efr_pkg::cfg_t cfg;
  efr_pkg::wr_t  wr;
  logic          adv;
  logic          rd_ok;
  logic [7:0]    rd_data;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign cfg_ready_o   = 1'b1;
  assign rd_ok         = (in_op_q == efr_pkg::OP_READ) &&
                         (32'(in_idx_q) < 32'(efr_pkg::STORE_DEPTH));

  efr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  efr_frame_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .opcode_i  (in_op_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .wr_o      (wr),
    .res_o     (res)
  );

  efr_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (adv),
    .rd_ok_i   (rd_ok),
    .rd_addr_i (efr_pkg::ADDR_W'(in_idx_q)),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[7:0];
      in_idx_q  <= s_axis_tdata[15:8];
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.errors, rd_data, res_q.length, res_q.status};

endmodule
